>>> src/lrpb_pkg.sv
`timescale 1ns / 1ps
// shared types, constants and helpers for the left/right pixel balance steering block
// no dependencies

package lrpb_pkg;

  localparam int COORD_W   = 12;
  localparam int LINES_W   = 7;
  localparam int FRAC_BITS = 15;
  localparam int SUM_W     = 28;
  localparam int DELTA_W   = 16;
  localparam int DEN_W     = COORD_W + 2;
  localparam int PAD_W     = SUM_W - COORD_W - FRAC_BITS;
  localparam int REG_IDX_W = 2;

  localparam logic [REG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_LINE_COUNT   = 2'd2;

  localparam logic [COORD_W-1:0] RESET_WIDTH  = 12'd640;
  localparam logic [COORD_W-1:0] RESET_HEIGHT = 12'd480;
  localparam logic [LINES_W-1:0] RESET_LINES  = 7'd10;

  localparam logic [SUM_W-1:0] NEG_LIMIT = 28'd32768;
  localparam logic [SUM_W-1:0] POS_LIMIT = 28'd32767;

  typedef struct packed {
    logic [COORD_W-1:0] left;
    logic [COORD_W-1:0] right;
    logic               last;
  } row_rec_t;

  typedef enum logic [1:0] {
    FS_CALC,
    FS_WAIT,
    FS_RUN
  } front_state_t;

  typedef enum logic [2:0] {
    BS_IDLE,
    BS_TERM,
    BS_FSTART,
    BS_FINAL,
    BS_EMIT
  } back_state_t;

  function automatic logic [LINES_W-1:0] eff_lines(input logic [LINES_W-1:0] lines);
    return (lines == '0) ? LINES_W'(1) : lines;
  endfunction

endpackage

>>> src/lrpb_div.sv
`timescale 1ns / 1ps
// restoring unsigned divider, one quotient bit per cycle
// no dependencies

module lrpb_div #(
  parameter int NUM_W = 28,
  parameter int DEN_W = 14
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             busy,
  output logic             done,
  output logic [NUM_W-1:0] quot
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [DEN_W-1:0] rem;
  logic [DEN_W-1:0] rem_next;
  logic [DEN_W-1:0] den_q;
  logic [NUM_W-1:0] acc;
  logic [CNT_W-1:0] cnt;
  logic [DEN_W:0]   trial;
  logic             fits;

  always_comb begin
    trial    = {rem, acc[NUM_W-1]};
    fits     = trial >= {1'b0, den_q};
    rem_next = fits ? DEN_W'(trial - {1'b0, den_q}) : trial[DEN_W-1:0];
  end

  assign quot = acc;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start && !busy) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(NUM_W);
      end else if (busy) begin
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      rem   <= '0;
      acc   <= num;
      den_q <= den;
    end else if (busy) begin
      rem <= rem_next;
      acc <= {acc[NUM_W-2:0], fits};
    end
  end

endmodule

>>> src/lrpb_fifo.sv
`timescale 1ns / 1ps
// short queue of closed-row records between front and back
// depends on lrpb_pkg

module lrpb_fifo #(
  parameter int DEPTH = 4
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  lrpb_pkg::row_rec_t wr_rec,
  input  logic               pop,
  output lrpb_pkg::row_rec_t rd_rec,
  output logic               full,
  output logic               empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  lrpb_pkg::row_rec_t mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] fill;

  assign full   = fill == CNT_W'(DEPTH);
  assign empty  = fill == '0;
  assign rd_rec = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wr_rec;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        fill <= fill + CNT_W'(1);
      end else if (pop && !push) begin
        fill <= fill - CNT_W'(1);
      end
    end
  end

endmodule

>>> src/lrpb_front.sv
`timescale 1ns / 1ps
// front end: raster position tracking, row sampling and left/right pixel counts
// depends on lrpb_pkg and lrpb_div

module lrpb_front (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [lrpb_pkg::COORD_W-1:0]   frame_width,
  input  logic [lrpb_pkg::COORD_W-1:0]   frame_height,
  input  logic [lrpb_pkg::LINES_W-1:0]   line_count,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           pixel_on,
  input  logic                           frame_end,
  output logic                           q_push,
  output lrpb_pkg::row_rec_t             q_rec,
  input  logic                           q_full
);

  localparam int CW = lrpb_pkg::COORD_W;

  lrpb_pkg::front_state_t state;
  lrpb_pkg::front_state_t state_next;

  logic          stale;
  logic [CW-1:0] col;
  logic [CW-1:0] row;
  logic [CW-1:0] nsr;
  logic [CW-1:0] left_cnt;
  logic [CW-1:0] right_cnt;
  logic [CW-1:0] row_step;

  logic          div_start;
  logic          div_busy;
  logic          div_done;
  logic [CW-1:0] div_quot;

  logic          accept;
  logic          fresh;
  logic [CW-1:0] half;
  logic          row_hit;
  logic [CW:0]   col_inc;
  logic          eor;
  logic          in_left;
  logic          in_right;
  logic [CW-1:0] left_now;
  logic [CW-1:0] right_now;
  logic          close;
  logic [CW:0]   nsr_sum;
  logic [CW-1:0] nsr_sat;

  lrpb_div #(
    .NUM_W (CW),
    .DEN_W (lrpb_pkg::LINES_W)
  ) u_step_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (frame_height),
    .den   (lrpb_pkg::eff_lines(line_count)),
    .busy  (div_busy),
    .done  (div_done),
    .quot  (div_quot)
  );

  always_comb begin
    accept    = in_valid && in_ready;
    fresh     = (col == '0) && (row == '0);
    half      = frame_width >> 1;
    row_hit   = (row == nsr) && (row < frame_height);
    col_inc   = {1'b0, col} + (CW + 1)'(1);
    eor       = col_inc >= {1'b0, frame_width};
    in_left   = pixel_on && row_hit && (col != '0) && (col <= half);
    in_right  = pixel_on && row_hit && (col > half) && (col < frame_width);
    left_now  = left_cnt + CW'(in_left);
    right_now = right_cnt + CW'(in_right);
    close     = (eor || frame_end) && row_hit;
    nsr_sum   = {1'b0, nsr} + {1'b0, row_step};
    nsr_sat   = nsr_sum[CW] ? '1 : nsr_sum[CW-1:0];
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      lrpb_pkg::FS_CALC: begin
        state_next = cfg_we ? lrpb_pkg::FS_CALC : lrpb_pkg::FS_WAIT;
      end
      lrpb_pkg::FS_WAIT: begin
        if (div_done) begin
          state_next = (stale || cfg_we) ? lrpb_pkg::FS_CALC : lrpb_pkg::FS_RUN;
        end
      end
      lrpb_pkg::FS_RUN: begin
        if (accept && frame_end) begin
          state_next = lrpb_pkg::FS_CALC;
        end else if (cfg_we && fresh) begin
          state_next = lrpb_pkg::FS_CALC;
        end
      end
      default: begin
        state_next = lrpb_pkg::FS_CALC;
      end
    endcase
  end

  // outputs
  always_comb begin
    div_start = 1'b0;
    in_ready  = 1'b0;
    case (state)
      lrpb_pkg::FS_CALC: begin
        div_start = !cfg_we && !div_busy;
      end
      lrpb_pkg::FS_RUN: begin
        in_ready = !q_full;
      end
      default: begin
        div_start = 1'b0;
      end
    endcase
  end

  always_comb begin
    q_push      = accept && (close || frame_end);
    q_rec.left  = left_now;
    q_rec.right = right_now;
    q_rec.last  = frame_end;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lrpb_pkg::FS_CALC;
      stale <= 1'b0;
    end else begin
      state <= state_next;
      if (state != lrpb_pkg::FS_WAIT) begin
        stale <= 1'b0;
      end else if (cfg_we) begin
        stale <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if ((state == lrpb_pkg::FS_WAIT) && div_done) begin
      row_step <= (div_quot == '0) ? CW'(1) : div_quot;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col       <= '0;
      row       <= '0;
      nsr       <= '0;
      left_cnt  <= '0;
      right_cnt <= '0;
    end else if (accept) begin
      if (frame_end) begin
        col       <= '0;
        row       <= '0;
        nsr       <= '0;
        left_cnt  <= '0;
        right_cnt <= '0;
      end else begin
        if (close) begin
          left_cnt  <= '0;
          right_cnt <= '0;
          nsr       <= nsr_sat;
        end else begin
          left_cnt  <= left_now;
          right_cnt <= right_now;
        end
        if (eor) begin
          col <= '0;
          row <= (row == '1) ? row : row + CW'(1);
        end else begin
          col <= col_inc[CW-1:0];
        end
      end
    end
  end

endmodule

>>> src/lrpb_back.sv
`timescale 1ns / 1ps
// back end: per-row balance term, accumulation, frame average and output register
// depends on lrpb_pkg and lrpb_div

module lrpb_back (
  input  logic                                clk,
  input  logic                                rst,
  input  logic [lrpb_pkg::LINES_W-1:0]        line_count,
  input  lrpb_pkg::row_rec_t                  q_rec,
  input  logic                                q_empty,
  output logic                                q_pop,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [lrpb_pkg::DELTA_W-1:0] steer_delta,
  output logic [lrpb_pkg::COORD_W-1:0]        rows_used
);

  localparam int CW = lrpb_pkg::COORD_W;
  localparam int SW = lrpb_pkg::SUM_W;
  localparam int DW = lrpb_pkg::DEN_W;
  localparam int OW = lrpb_pkg::DELTA_W;

  lrpb_pkg::back_state_t state;
  lrpb_pkg::back_state_t state_next;

  lrpb_pkg::row_rec_t cur;
  logic [SW-1:0]      sum;
  logic [CW-1:0]      used;

  logic          div_start;
  logic          div_busy;
  logic          div_done;
  logic [SW-1:0] div_quot;
  logic [SW-1:0] div_num;
  logic [DW-1:0] div_den;
  logic          use_final;
  logic          acc_term;
  logic          load_out;

  logic [CW:0]   head_tot;
  logic [CW-1:0] diff_mag;
  logic [SW-1:0] term_num;
  logic [SW-1:0] sum_mag;
  logic [SW:0]   term_ext;
  logic [SW:0]   term_val;
  logic [SW:0]   sum_wide;
  logic [SW-1:0] sum_sat;
  logic [OW-1:0] delta_val;

  lrpb_div #(
    .NUM_W (SW),
    .DEN_W (DW)
  ) u_bal_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .busy  (div_busy),
    .done  (div_done),
    .quot  (div_quot)
  );

  always_comb begin
    head_tot = {1'b0, q_rec.left} + {1'b0, q_rec.right};
    diff_mag = (q_rec.right >= q_rec.left) ? q_rec.right - q_rec.left
                                           : q_rec.left - q_rec.right;
    term_num = {{lrpb_pkg::PAD_W{1'b0}}, diff_mag, {lrpb_pkg::FRAC_BITS{1'b0}}};
    sum_mag  = sum[SW-1] ? (~sum) + SW'(1) : sum;
    if (use_final) begin
      div_num = sum_mag;
      div_den = {{(DW - lrpb_pkg::LINES_W){1'b0}}, lrpb_pkg::eff_lines(line_count)};
    end else begin
      div_num = term_num;
      div_den = {head_tot, 1'b0};
    end
  end

  // term accumulation with saturation
  always_comb begin
    term_ext = {1'b0, div_quot};
    term_val = (cur.right < cur.left) ? (~term_ext) + (SW + 1)'(1) : term_ext;
    sum_wide = {sum[SW-1], sum} + term_val;
    if (sum_wide[SW] != sum_wide[SW-1]) begin
      sum_sat = sum_wide[SW] ? {1'b1, {(SW - 1){1'b0}}} : {1'b0, {(SW - 1){1'b1}}};
    end else begin
      sum_sat = sum_wide[SW-1:0];
    end
  end

  // frame average clamped to the output range
  always_comb begin
    if (sum[SW-1]) begin
      if (div_quot > lrpb_pkg::NEG_LIMIT) begin
        delta_val = {1'b1, {(OW - 1){1'b0}}};
      end else begin
        delta_val = (~div_quot[OW-1:0]) + OW'(1);
      end
    end else begin
      if (div_quot > lrpb_pkg::POS_LIMIT) begin
        delta_val = {1'b0, {(OW - 1){1'b1}}};
      end else begin
        delta_val = div_quot[OW-1:0];
      end
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      lrpb_pkg::BS_IDLE: begin
        if (!q_empty) begin
          if (head_tot != '0) begin
            state_next = lrpb_pkg::BS_TERM;
          end else if (q_rec.last) begin
            state_next = lrpb_pkg::BS_FSTART;
          end
        end
      end
      lrpb_pkg::BS_TERM: begin
        if (div_done) begin
          state_next = cur.last ? lrpb_pkg::BS_FSTART : lrpb_pkg::BS_IDLE;
        end
      end
      lrpb_pkg::BS_FSTART: begin
        state_next = lrpb_pkg::BS_FINAL;
      end
      lrpb_pkg::BS_FINAL: begin
        if (div_done) begin
          state_next = lrpb_pkg::BS_EMIT;
        end
      end
      lrpb_pkg::BS_EMIT: begin
        if (!out_valid || out_ready) begin
          state_next = lrpb_pkg::BS_IDLE;
        end
      end
      default: begin
        state_next = lrpb_pkg::BS_IDLE;
      end
    endcase
  end

  // outputs
  always_comb begin
    q_pop     = 1'b0;
    div_start = 1'b0;
    use_final = 1'b0;
    acc_term  = 1'b0;
    load_out  = 1'b0;
    case (state)
      lrpb_pkg::BS_IDLE: begin
        q_pop     = !q_empty;
        div_start = !q_empty && (head_tot != '0);
      end
      lrpb_pkg::BS_TERM: begin
        acc_term = div_done;
      end
      lrpb_pkg::BS_FSTART: begin
        div_start = 1'b1;
        use_final = 1'b1;
      end
      lrpb_pkg::BS_EMIT: begin
        load_out = !out_valid || out_ready;
      end
      default: begin
        q_pop = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= lrpb_pkg::BS_IDLE;
      sum       <= '0;
      used      <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (acc_term) begin
        sum  <= sum_sat;
        used <= (used == '1) ? used : used + CW'(1);
      end else if (load_out) begin
        sum  <= '0;
        used <= '0;
      end
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur <= q_rec;
    end
    if (load_out) begin
      steer_delta <= delta_val;
      rows_used   <= used;
    end
  end

  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> !q_empty)
    else $error("queue popped while empty");

  a_done_state: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == lrpb_pkg::BS_TERM || state == lrpb_pkg::BS_FINAL))
    else $error("divider finished outside a waiting state");

  a_emit_clears: assert property (@(posedge clk) disable iff (rst)
    load_out |=> (sum == '0 && used == '0))
    else $error("frame totals not cleared after emit");

  a_start_idle: assert property (@(posedge clk) disable iff (rst)
    div_start |-> !div_busy)
    else $error("divider started while busy");

endmodule

>>> src/left_right_pixel_balance_steering_core.sv
`timescale 1ns / 1ps
// Left/right pixel balance steering: takes a binary mask one pixel per word in raster
// order and gives one signed steering delta per frame.
// Channels: cfg_we/cfg_index/cfg_wdata write frame_width, frame_height and line_count
// (index 0, 1, 2) with no handshake; in_valid/in_ready carry pixel_on and frame_end;
// out_valid/out_ready carry steer_delta (Q15) and rows_used.
// Throughput: one pixel per cycle while the row queue has room and no row step is being
// computed. A row record is queued only for sampled rows and at frame end; the back end
// passes each sampled row with set pixels through a serial divider, so rows long enough
// to hide the division stream without stalls, while narrower ones stall the input once
// the QUEUE_DEPTH-entry queue fills.
// Frame start: after reset, after every frame_end word and after a register write at
// the start of a frame, the row step (height / lines) is computed by a serial divider;
// in_ready stays low until it is done.
// Result: the frame_end word queues a record; the back end divides its row term when it
// closes a sampled row with set pixels, then the frame average, after any rows ahead of it.
// Stall: the result is held in an output register; the back end keeps working on the
// next frame's rows and waits only if a second result is ready before the first is
// taken. Reset clears all frame state and loads 640 x 480 with 10 lines.

module left_right_pixel_balance_steering_core #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [lrpb_pkg::REG_IDX_W-1:0]      cfg_index,
  input  logic [lrpb_pkg::COORD_W-1:0]        cfg_wdata,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                pixel_on,
  input  logic                                frame_end,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [lrpb_pkg::DELTA_W-1:0] steer_delta,
  output logic [lrpb_pkg::COORD_W-1:0]        rows_used
);

  logic [lrpb_pkg::COORD_W-1:0] frame_width;
  logic [lrpb_pkg::COORD_W-1:0] frame_height;
  logic [lrpb_pkg::LINES_W-1:0] line_count;

  logic               q_push;
  logic               q_pop;
  logic               q_full;
  logic               q_empty;
  lrpb_pkg::row_rec_t q_wr_rec;
  lrpb_pkg::row_rec_t q_rd_rec;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= lrpb_pkg::RESET_WIDTH;
      frame_height <= lrpb_pkg::RESET_HEIGHT;
      line_count   <= lrpb_pkg::RESET_LINES;
    end else if (cfg_we) begin
      case (cfg_index)
        lrpb_pkg::REG_FRAME_WIDTH:  frame_width  <= cfg_wdata;
        lrpb_pkg::REG_FRAME_HEIGHT: frame_height <= cfg_wdata;
        lrpb_pkg::REG_LINE_COUNT:   line_count   <= cfg_wdata[lrpb_pkg::LINES_W-1:0];
        default: begin
        end
      endcase
    end
  end

  lrpb_front u_front (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .frame_width  (frame_width),
    .frame_height (frame_height),
    .line_count   (line_count),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .pixel_on     (pixel_on),
    .frame_end    (frame_end),
    .q_push       (q_push),
    .q_rec        (q_wr_rec),
    .q_full       (q_full)
  );

  lrpb_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_row_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (q_push),
    .wr_rec (q_wr_rec),
    .pop    (q_pop),
    .rd_rec (q_rd_rec),
    .full   (q_full),
    .empty  (q_empty)
  );

  lrpb_back u_back (
    .clk         (clk),
    .rst         (rst),
    .line_count  (line_count),
    .q_rec       (q_rd_rec),
    .q_empty     (q_empty),
    .q_pop       (q_pop),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .steer_delta (steer_delta),
    .rows_used   (rows_used)
  );

endmodule

>>> verif/left_right_pixel_balance_steering_core_test.sv
`timescale 1ns / 1ps
// self-checking bench for left_right_pixel_balance_steering_core: streams mask frames
// under random stalls and checks each steering word against an in-bench predictor
// depends on lrpb_pkg and the core

module left_right_pixel_balance_steering_core_test;

  localparam int  POS_SAT   = 4095;
  localparam longint BAL_MAX = 134217727;
  localparam longint BAL_MIN = -134217728;

  typedef struct {
    bit pix;
    bit fend;
  } mask_word_t;

  typedef struct {
    logic signed [lrpb_pkg::DELTA_W-1:0] delta;
    logic [lrpb_pkg::COORD_W-1:0]        rows;
  } steer_word_t;

  logic                                clk = 1'b0;
  logic                                rst = 1'b1;
  logic                                cfg_we = 1'b0;
  logic [lrpb_pkg::REG_IDX_W-1:0]      cfg_index = '0;
  logic [lrpb_pkg::COORD_W-1:0]        cfg_wdata = '0;
  logic                                in_valid = 1'b0;
  logic                                in_ready;
  logic                                pixel_on = 1'b0;
  logic                                frame_end = 1'b0;
  logic                                out_valid;
  logic                                out_ready = 1'b0;
  logic signed [lrpb_pkg::DELTA_W-1:0] steer_delta;
  logic [lrpb_pkg::COORD_W-1:0]        rows_used;

  left_right_pixel_balance_steering_core dut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .pixel_on(pixel_on),
    .frame_end(frame_end),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .steer_delta(steer_delta),
    .rows_used(rows_used)
  );

  mask_word_t  pending_pixels[$];
  steer_word_t expected_steer[$];
  mask_word_t  next_px;
  steer_word_t got_steer;
  bit          in_fire = 1'b0;
  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;
  int          mismatches = 0;

  // predictor state
  int     m_width, m_height, m_lines;
  int     col, row, step, next_row, left_cnt, right_cnt, used;
  longint bal;

  function automatic int lines_eff();
    return (m_lines != 0) ? m_lines : 1;
  endfunction

  function automatic int step_calc();
    int s;
    s = m_height / lines_eff();
    return (s != 0) ? s : 1;
  endfunction

  function automatic bit on_sampled_row();
    return (row == next_row) && (row < m_height);
  endfunction

  task automatic clear_frame();
    col = 0;
    row = 0;
    next_row = 0;
    left_cnt = 0;
    right_cnt = 0;
    bal = 0;
    used = 0;
  endtask

  task automatic balance_step(input bit pix, input bit fend);
    int          half;
    int          tot;
    bit          row_end;
    longint      term;
    longint      q;
    steer_word_t res;
    half = m_width / 2;
    if (col == 0 && row == 0) step = step_calc();
    if (pix && on_sampled_row()) begin
      if (col >= 1 && col <= half) left_cnt++;
      else if (col > half && col < m_width) right_cnt++;
    end
    row_end = (col + 1) >= m_width;
    // close the row, also a partial one cut by frame end
    if ((row_end || fend) && on_sampled_row()) begin
      tot = left_cnt + right_cnt;
      if (tot > 0) begin
        term = ((longint'(right_cnt) - longint'(left_cnt)) * (longint'(1) << 15))
               / longint'(2 * tot);
        bal = bal + term;
        if (bal > BAL_MAX) bal = BAL_MAX;
        if (bal < BAL_MIN) bal = BAL_MIN;
        if (used < POS_SAT) used++;
      end
      next_row = next_row + step;
      if (next_row > POS_SAT) next_row = POS_SAT;
      left_cnt = 0;
      right_cnt = 0;
    end
    if (fend) begin
      q = bal / longint'(lines_eff());
      if (q > 32767) q = 32767;
      if (q < -32768) q = -32768;
      res.delta = q[15:0];
      res.rows = used[11:0];
      expected_steer.push_back(res);
      clear_frame();
    end else if (row_end) begin
      col = 0;
      if (row < POS_SAT) row++;
    end else begin
      col++;
    end
  endtask

  initial begin
    forever #2 clk = ~clk;
  end

  // accept tracking, predictor and result check
  always @(posedge clk) begin
    in_fire = !rst && in_valid && in_ready;
    if (rst) begin
      m_width = lrpb_pkg::RESET_WIDTH;
      m_height = lrpb_pkg::RESET_HEIGHT;
      m_lines = lrpb_pkg::RESET_LINES;
      clear_frame();
      step = step_calc();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          lrpb_pkg::REG_FRAME_WIDTH:  m_width = cfg_wdata;
          lrpb_pkg::REG_FRAME_HEIGHT: m_height = cfg_wdata;
          lrpb_pkg::REG_LINE_COUNT:   m_lines = cfg_wdata[6:0];
          default: ;
        endcase
      end
      if (in_fire) balance_step(pixel_on, frame_end);
      if (out_valid && out_ready) begin
        if (expected_steer.size() == 0) begin
          $display("%0t unexpected word: steer_delta %0d rows_used %0d",
                   $time, steer_delta, rows_used);
          mismatches++;
        end else begin
          got_steer = expected_steer.pop_front();
          if (steer_delta !== got_steer.delta) begin
            $display("%0t steer_delta expected %0d actual %0d",
                     $time, got_steer.delta, steer_delta);
            mismatches++;
          end
          if (rows_used !== got_steer.rows) begin
            $display("%0t rows_used expected %0d actual %0d",
                     $time, got_steer.rows, rows_used);
            mismatches++;
          end
        end
      end
    end
  end

  // pixel driver and result stall
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_fire) begin
      if (pending_pixels.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        next_px = pending_pixels.pop_front();
        pixel_on <= next_px.pix;
        frame_end <= next_px.fend;
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
    out_ready <= !rst && ($urandom_range(99) >= recv_idle_pct);
  end

  task automatic push_pixel(input bit pix, input bit fend);
    mask_word_t w;
    w.pix = pix;
    w.fend = fend;
    pending_pixels.push_back(w);
  endtask

  task automatic push_frame(input int len, input int density);
    for (int i = 0; i < len; i++) begin
      push_pixel($urandom_range(99) < density, i == len - 1);
    end
  endtask

  task automatic wait_drained();
    while (pending_pixels.size() != 0 || in_valid || expected_steer.size() != 0) begin
      @(posedge clk);
    end
    repeat (100) @(posedge clk);
  endtask

  task automatic set_config(input int w, input int h, input int lines);
    wait_drained();
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= lrpb_pkg::REG_FRAME_WIDTH;
    cfg_wdata <= w[11:0];
    @(negedge clk);
    cfg_index <= lrpb_pkg::REG_FRAME_HEIGHT;
    cfg_wdata <= h[11:0];
    @(negedge clk);
    cfg_index <= lrpb_pkg::REG_LINE_COUNT;
    cfg_wdata <= {5'($urandom_range(0, 31)), lines[6:0]};
    // unused index, must be ignored
    @(negedge clk);
    cfg_index <= 2'd3;
    cfg_wdata <= 12'($urandom);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    int phase_px;
    int group;
    int w, h, lines, area, len, density, r;
    group = 0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 25;
          recv_idle_pct = 73;
        end
        1: begin
          send_idle_pct = 73;
          recv_idle_pct = 25;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      if (phase == 0) begin
        // reset setting, column 0 not counted, short frame
        push_pixel(1, 0); push_pixel(1, 0); push_pixel(1, 0);
        push_pixel(0, 0); push_pixel(1, 1);
        // all right in sampled row, unsampled row full
        set_config(4, 2, 1);
        push_pixel(1, 0); push_pixel(0, 0); push_pixel(0, 0); push_pixel(1, 0);
        push_pixel(1, 0); push_pixel(1, 0); push_pixel(1, 0); push_pixel(1, 1);
        // minimum width, step forced to one, empty frame
        set_config(2, 1, 64);
        push_pixel(1, 0); push_pixel(1, 1);
        push_pixel(0, 0); push_pixel(0, 1);
        // zero line count
        set_config(3, 2, 0);
        push_pixel(0, 0); push_pixel(0, 0); push_pixel(1, 0);
        push_pixel(0, 0); push_pixel(1, 0); push_pixel(1, 1);
        // tiny width
        set_config(1, 3, 1);
        push_pixel(1, 0); push_pixel(1, 0); push_pixel(1, 1);
      end
      phase_px = 0;
      while (phase_px < 430) begin
        if (group % 3 == 0) begin
          case ((group / 3) % 4)
            0: begin w = 2048; h = 2048; lines = 64; end
            1: begin w = 4095; h = 4095; lines = 127; end
            2: begin w = 0; h = 0; lines = 0; end
            default: begin w = $urandom_range(2, 6); h = $urandom_range(1, 4); lines = 64; end
          endcase
        end else begin
          r = $urandom_range(99);
          w = (r < 5) ? $urandom_range(0, 1) :
              (r < 10) ? $urandom_range(1024, 4095) : $urandom_range(2, 12);
          r = $urandom_range(99);
          h = (r < 5) ? 0 : (r < 10) ? $urandom_range(1024, 4095) : $urandom_range(1, 8);
          r = $urandom_range(99);
          lines = (r < 8) ? $urandom_range(0, 127) : $urandom_range(1, 10);
        end
        group++;
        set_config(w, h, lines);
        repeat ($urandom_range(1, 4)) begin
          area = w * h;
          if ($urandom_range(99) < 70 && area > 0 && area <= 64) len = area;
          else len = $urandom_range(1, 64);
          r = $urandom_range(9);
          density = (r == 0) ? 0 : (r == 1) ? 100 : $urandom_range(0, 100);
          push_frame(len, density);
          phase_px += len;
        end
      end
    end
    wait_drained();
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("FAIL");
    $finish;
  end

endmodule

>>> left_right_pixel_balance_steering_core.f
src/lrpb_pkg.sv
src/lrpb_div.sv
src/lrpb_fifo.sv
src/lrpb_front.sv
src/lrpb_back.sv
src/left_right_pixel_balance_steering_core.sv
verif/left_right_pixel_balance_steering_core_test.sv
